>>> rtl/core/mbn_pkg.sv
`default_nettype none
package mbn_pkg;

   localparam int POS_FRAC_BITS  = 16;
   localparam int NORM_FRAC_BITS = 14;

   localparam int MODE_W = 2;
   localparam int POS_W  = 32;
   localparam int NRM_W  = 16;
   localparam int TEX_W  = 32;

   localparam logic [MODE_W-1:0] MODE_CLEAR     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ACCUM     = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TRANSFORM = 2'd2;
   localparam logic [MODE_W-1:0] MODE_NONE      = 2'd3;

   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] REG_KEEP_ASPECT = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ROTATE_HALF = 8'd1;

   // Position differences are held in 35 signed bits; magnitudes stay below 2^34.
   localparam int DIFF_W = POS_W + 3;
   localparam int DEN_W  = POS_W + 2;
   localparam int NUM_A  = POS_W + 2 + POS_FRAC_BITS;
   localparam int NUM_B  = NRM_W + 1 + 2 * NORM_FRAC_BITS;
   localparam int NUM_W  = (NUM_A > NUM_B) ? NUM_A : NUM_B;
   localparam int CNT_W  = $clog2(NUM_W + 1);

   // Squared length fits 32 bits before it is scaled by N^2.
   localparam int SQ_W  = 2 * NRM_W + 2 * NORM_FRAC_BITS;
   localparam int LEN_W = SQ_W / 2;
   localparam int VEC_W = NRM_W + 1;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [POS_W-1:0]  pos_x;
      logic [POS_W-1:0]  pos_y;
      logic [POS_W-1:0]  pos_z;
      logic [NRM_W-1:0]  norm_x;
      logic [NRM_W-1:0]  norm_y;
      logic [NRM_W-1:0]  norm_z;
      logic [TEX_W-1:0]  tex_u;
      logic [TEX_W-1:0]  tex_v;
   } item_type;

   typedef struct packed {
      logic valid;
      logic pop;
   } queue_ctl_type;

   function automatic logic signed [POS_W-1:0] sat32(input logic signed [NUM_W+1:0] v);
      logic signed [NUM_W+1:0] hi;
      logic signed [NUM_W+1:0] lo;
      hi = (NUM_W+2)'(signed'({1'b0, {(POS_W-1){1'b1}}}));
      lo = -hi - (NUM_W+2)'(1);
      if (v > hi) begin
         sat32 = hi[POS_W-1:0];
      end else if (v < lo) begin
         sat32 = lo[POS_W-1:0];
      end else begin
         sat32 = v[POS_W-1:0];
      end
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/mbn_front.sv
`default_nettype none
module mbn_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire mbn_pkg::item_type  push_item,
   output logic                    full,
   input  wire logic               pop,
   output logic                    item_valid,
   output mbn_pkg::item_type       item
);
   import mbn_pkg::*;

   item_type    mem [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        do_push, do_pop;

   assign full       = (count_ff == 2'd2);
   assign item_valid = (count_ff != 2'd0);
   assign item       = mem[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && item_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end
endmodule
`default_nettype wire

>>> rtl/core/mbn_divu.sv
`default_nettype none
module mbn_divu (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [mbn_pkg::NUM_W-1:0] num,
   input  wire logic [mbn_pkg::DEN_W-1:0] den,
   output logic                           done,
   output logic [mbn_pkg::NUM_W-1:0]      quo
);
   import mbn_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [NUM_W-1:0]    num_ff, num_in;
   logic [DEN_W-1:0]    den_ff, den_in;
   logic [DEN_W:0]      rem_ff, rem_in;
   logic [NUM_W-1:0]    quo_ff, quo_in;
   logic [DEN_W:0]      shifted;
   logic                fits;

   assign done = done_ff;
   assign quo  = quo_ff;

   always_comb begin
      shifted   = {rem_ff[DEN_W-1:0], num_ff[NUM_W-1]};
      fits      = (shifted >= {1'b0, den_ff});
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      num_in    = num_ff;
      den_in    = den_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
         quo_in  = '0;
      end else if (busy_ff) begin
         num_in = {num_ff[NUM_W-2:0], 1'b0};
         rem_in = fits ? (shifted - {1'b0, den_ff}) : shifted;
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end
endmodule
`default_nettype wire

>>> rtl/core/mbn_back.sv
`default_nettype none
module mbn_back (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           item_valid,
   input  wire mbn_pkg::item_type              item,
   output logic                                item_pop,
   input  wire logic                           csr_write,
   input  wire logic [mbn_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [mbn_pkg::CSR_DATA_W-1:0] csr_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic signed [mbn_pkg::POS_W-1:0]    rsp_out_x,
   output logic signed [mbn_pkg::POS_W-1:0]    rsp_out_y,
   output logic signed [mbn_pkg::POS_W-1:0]    rsp_out_z,
   output logic signed [mbn_pkg::NRM_W-1:0]    rsp_out_nx,
   output logic signed [mbn_pkg::NRM_W-1:0]    rsp_out_ny,
   output logic signed [mbn_pkg::NRM_W-1:0]    rsp_out_nz,
   output logic [mbn_pkg::TEX_W-1:0]           rsp_out_u,
   output logic [mbn_pkg::TEX_W-1:0]           rsp_out_v
);
   import mbn_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_PISSUE = 3'd1;
   localparam logic [2:0] ST_PWAIT  = 3'd2;
   localparam logic [2:0] ST_SQR    = 3'd3;
   localparam logic [2:0] ST_SQRT   = 3'd4;
   localparam logic [2:0] ST_NISSUE = 3'd5;
   localparam logic [2:0] ST_NWAIT  = 3'd6;
   localparam logic [2:0] ST_FIN    = 3'd7;

   localparam logic signed [DIFF_W-1:0] ONE_D = DIFF_W'(1);
   localparam logic signed [NUM_W+1:0]  HALF_P = (NUM_W+2)'(1) <<< (POS_FRAC_BITS - 1);
   localparam logic signed [NUM_W+1:0]  ONE_P  = (NUM_W+2)'(1) <<< POS_FRAC_BITS;
   localparam logic [SQ_W-1:0]          SQ_TOP = SQ_W'(1) << (SQ_W - 2);

   logic [2:0]              state_ff, state_in;
   logic [1:0]              job_ff, job_in;
   item_type                item_ff, item_in;
   logic                    keep_ff, keep_in, rot_ff, rot_in;
   logic [POS_W-1:0]        lx_ff, ly_ff, lz_ff, hx_ff, hy_ff, hz_ff;
   logic [POS_W-1:0]        lx_in, ly_in, lz_in, hx_in, hy_in, hz_in;
   logic signed [POS_W-1:0] ox_ff, oy_ff, oz_ff, ox_in, oy_in, oz_in;
   logic signed [NRM_W-1:0] nx_ff, ny_ff, nz_ff, nx_in, ny_in, nz_in;
   logic [SQ_W-1:0]         s_ff, s_in, sv_ff, sv_in, sr_ff, sr_in, sb_ff, sb_in;
   logic [LEN_W-1:0]        len_ff, len_in;
   logic                    neg_ff, neg_in;
   logic                    div_start;
   logic [NUM_W-1:0]        div_num;
   logic [DEN_W-1:0]        div_den;
   logic                    div_done;
   logic [NUM_W-1:0]        div_quo;

   logic                    rv_ff, rv_in;
   logic signed [POS_W-1:0] rx_ff, ry_ff, rz_ff, rx_in, ry_in, rz_in;
   logic signed [NRM_W-1:0] rnx_ff, rny_ff, rnz_ff, rnx_in, rny_in, rnz_in;
   logic [TEX_W-1:0]        ru_ff, rv2_ff, ru_in, rv2_in;

   logic signed [DIFF_W-1:0] ex, ey, ez, fx, fy, fz, pdiff, pden;
   logic [DIFF_W-1:0]        pmag;
   logic signed [VEC_W-1:0]  vcomp;
   logic [VEC_W-1:0]         vmag;
   logic [2*VEC_W-1:0]       vsq;
   logic [SQ_W-1:0]          s_sum, sq_try;
   logic signed [NUM_W+1:0]  qs, pres;
   logic                     out_free;

   function automatic logic signed [DIFF_W-1:0] sx(input logic [POS_W-1:0] v);
      sx = DIFF_W'(signed'(v));
   endfunction

   mbn_divu u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_comb begin
      ex = sx(hx_ff) - sx(lx_ff);
      ey = sx(hy_ff) - sx(ly_ff);
      ez = sx(hz_ff) - sx(lz_ff);
      fx = (ex < ONE_D) ? ONE_D : ex;
      fy = (ey < ONE_D) ? ONE_D : ey;
      fz = (ez < ONE_D) ? ONE_D : ez;
      pdiff = '0;
      pden  = fy;
      if (keep_ff) begin
         unique case (job_ff)
            2'd0: pdiff = (sx(item_ff.pos_x) <<< 1) - sx(lx_ff) - sx(hx_ff);
            2'd1: pdiff = (sx(item_ff.pos_z) <<< 1) - sx(lz_ff) - sx(hz_ff);
            default: pdiff = sx(item_ff.pos_y) - sx(ly_ff);
         endcase
         pden = (job_ff == 2'd2) ? fy : (fy <<< 1);
      end else begin
         unique case (job_ff)
            2'd0: begin
               pdiff = sx(item_ff.pos_x) - sx(lx_ff);
               pden  = fx;
            end
            2'd1: begin
               pdiff = sx(hz_ff) - sx(item_ff.pos_z);
               pden  = fz;
            end
            default: begin
               pdiff = sx(item_ff.pos_y) - sx(ly_ff);
               pden  = fy;
            end
         endcase
      end
      pmag = pdiff[DIFF_W-1] ? DIFF_W'(-pdiff) : DIFF_W'(pdiff);

      // Normal remapped to (x, -z, y).
      unique case (job_ff)
         2'd0: vcomp = VEC_W'(signed'(item_ff.norm_x));
         2'd1: vcomp = -VEC_W'(signed'(item_ff.norm_z));
         default: vcomp = VEC_W'(signed'(item_ff.norm_y));
      endcase
      vmag  = vcomp[VEC_W-1] ? VEC_W'(-vcomp) : VEC_W'(vcomp);
      vsq   = vmag * vmag;
      s_sum = s_ff + SQ_W'(vsq);
      sq_try = sr_ff + sb_ff;

      qs = neg_ff ? -(NUM_W+2)'(div_quo) : (NUM_W+2)'(div_quo);
      if (keep_ff && job_ff == 2'd0) begin
         pres = HALF_P + qs;
      end else if (keep_ff && job_ff == 2'd1) begin
         pres = HALF_P - qs;
      end else begin
         pres = qs;
      end
   end

   assign out_free = !rv_ff || !rsp_stall;

   always_comb begin
      state_in  = state_ff;
      job_in    = job_ff;
      item_in   = item_ff;
      keep_in   = keep_ff;
      rot_in    = rot_ff;
      lx_in = lx_ff; ly_in = ly_ff; lz_in = lz_ff;
      hx_in = hx_ff; hy_in = hy_ff; hz_in = hz_ff;
      ox_in = ox_ff; oy_in = oy_ff; oz_in = oz_ff;
      nx_in = nx_ff; ny_in = ny_ff; nz_in = nz_ff;
      s_in  = s_ff;  sv_in = sv_ff; sr_in = sr_ff; sb_in = sb_ff;
      len_in = len_ff;
      neg_in = neg_ff;
      item_pop  = 1'b0;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      rv_in  = rv_ff && rsp_stall;
      rx_in  = rx_ff;  ry_in  = ry_ff;  rz_in  = rz_ff;
      rnx_in = rnx_ff; rny_in = rny_ff; rnz_in = rnz_ff;
      ru_in  = ru_ff;  rv2_in = rv2_ff;

      if (csr_write) begin
         if (csr_index == REG_KEEP_ASPECT) begin
            keep_in = csr_data[0];
         end else if (csr_index == REG_ROTATE_HALF) begin
            rot_in = csr_data[0];
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               item_in  = item;
               job_in   = 2'd0;
               unique case (item.mode)
                  MODE_CLEAR: begin
                     lx_in = {1'b0, {(POS_W-1){1'b1}}};
                     ly_in = {1'b0, {(POS_W-1){1'b1}}};
                     lz_in = {1'b0, {(POS_W-1){1'b1}}};
                     hx_in = {1'b1, {(POS_W-1){1'b0}}};
                     hy_in = {1'b1, {(POS_W-1){1'b0}}};
                     hz_in = {1'b1, {(POS_W-1){1'b0}}};
                  end
                  MODE_ACCUM: begin
                     if ($signed(item.pos_x) < $signed(lx_ff)) lx_in = item.pos_x;
                     if ($signed(item.pos_y) < $signed(ly_ff)) ly_in = item.pos_y;
                     if ($signed(item.pos_z) < $signed(lz_ff)) lz_in = item.pos_z;
                     if ($signed(item.pos_x) > $signed(hx_ff)) hx_in = item.pos_x;
                     if ($signed(item.pos_y) > $signed(hy_ff)) hy_in = item.pos_y;
                     if ($signed(item.pos_z) > $signed(hz_ff)) hz_in = item.pos_z;
                  end
                  MODE_TRANSFORM: state_in = ST_PISSUE;
                  MODE_NONE: state_in = ST_IDLE;
               endcase
            end
         end
         ST_PISSUE: begin
            div_start = 1'b1;
            div_num   = NUM_W'(pmag) << POS_FRAC_BITS;
            div_den   = DEN_W'(pden);
            neg_in    = pdiff[DIFF_W-1];
            state_in  = ST_PWAIT;
         end
         ST_PWAIT: begin
            if (div_done) begin
               unique case (job_ff)
                  2'd0: ox_in = sat32(pres);
                  2'd1: oy_in = sat32(pres);
                  default: oz_in = sat32(pres);
               endcase
               if (job_ff == 2'd2) begin
                  job_in   = 2'd0;
                  s_in     = '0;
                  state_in = ST_SQR;
               end else begin
                  job_in   = job_ff + 2'd1;
                  state_in = ST_PISSUE;
               end
            end
         end
         ST_SQR: begin
            s_in = s_sum;
            if (job_ff == 2'd2) begin
               job_in = 2'd0;
               if (s_sum == '0) begin
                  nx_in    = '0;
                  ny_in    = '0;
                  nz_in    = NRM_W'(1) << NORM_FRAC_BITS;
                  state_in = ST_FIN;
               end else begin
                  sv_in    = s_sum << (2 * NORM_FRAC_BITS);
                  sr_in    = '0;
                  sb_in    = SQ_TOP;
                  state_in = ST_SQRT;
               end
            end else begin
               job_in = job_ff + 2'd1;
            end
         end
         ST_SQRT: begin
            if (sv_ff >= sq_try) begin
               sv_in = sv_ff - sq_try;
               sr_in = (sr_ff >> 1) + sb_ff;
            end else begin
               sr_in = sr_ff >> 1;
            end
            sb_in = sb_ff >> 2;
            if (sb_ff == SQ_W'(1)) begin
               len_in   = sr_in[LEN_W-1:0];
               state_in = ST_NISSUE;
            end
         end
         ST_NISSUE: begin
            div_start = 1'b1;
            div_num   = NUM_W'(vmag) << (2 * NORM_FRAC_BITS);
            div_den   = DEN_W'(len_ff);
            neg_in    = vcomp[VEC_W-1];
            state_in  = ST_NWAIT;
         end
         ST_NWAIT: begin
            if (div_done) begin
               unique case (job_ff)
                  2'd0: nx_in = qs[NRM_W-1:0];
                  2'd1: ny_in = qs[NRM_W-1:0];
                  default: nz_in = qs[NRM_W-1:0];
               endcase
               if (job_ff == 2'd2) begin
                  state_in = ST_FIN;
               end else begin
                  job_in   = job_ff + 2'd1;
                  state_in = ST_NISSUE;
               end
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rv_in  = 1'b1;
               rz_in  = oz_ff;
               rnz_in = nz_ff;
               ru_in  = item_ff.tex_u;
               rv2_in = item_ff.tex_v;
               if (rot_ff) begin
                  rx_in  = sat32(ONE_P - (NUM_W+2)'(ox_ff));
                  ry_in  = sat32(ONE_P - (NUM_W+2)'(oy_ff));
                  rnx_in = -nx_ff;
                  rny_in = -ny_ff;
               end else begin
                  rx_in  = ox_ff;
                  ry_in  = oy_ff;
                  rnx_in = nx_ff;
                  rny_in = ny_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid  = rv_ff;
   assign rsp_out_x  = rx_ff;
   assign rsp_out_y  = ry_ff;
   assign rsp_out_z  = rz_ff;
   assign rsp_out_nx = rnx_ff;
   assign rsp_out_ny = rny_ff;
   assign rsp_out_nz = rnz_ff;
   assign rsp_out_u  = ru_ff;
   assign rsp_out_v  = rv2_ff;

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      item_ff <= item_in;
      ox_ff <= ox_in; oy_ff <= oy_in; oz_ff <= oz_in;
      nx_ff <= nx_in; ny_ff <= ny_in; nz_ff <= nz_in;
      s_ff  <= s_in;  sv_ff <= sv_in; sr_ff <= sr_in; sb_ff <= sb_in;
      len_ff <= len_in;
      neg_ff <= neg_in;
      rx_ff  <= rx_in;  ry_ff  <= ry_in;  rz_ff  <= rz_in;
      rnx_ff <= rnx_in; rny_ff <= rny_in; rnz_ff <= rnz_in;
      ru_ff  <= ru_in;  rv2_ff <= rv2_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         keep_ff  <= 1'b0;
         rot_ff   <= 1'b0;
         rv_ff    <= 1'b0;
         lx_ff <= {1'b0, {(POS_W-1){1'b1}}};
         ly_ff <= {1'b0, {(POS_W-1){1'b1}}};
         lz_ff <= {1'b0, {(POS_W-1){1'b1}}};
         hx_ff <= {1'b1, {(POS_W-1){1'b0}}};
         hy_ff <= {1'b1, {(POS_W-1){1'b0}}};
         hz_ff <= {1'b1, {(POS_W-1){1'b0}}};
      end else begin
         state_ff <= state_in;
         keep_ff  <= keep_in;
         rot_ff   <= rot_in;
         rv_ff    <= rv_in;
         lx_ff <= lx_in; ly_ff <= ly_in; lz_ff <= lz_in;
         hx_ff <= hx_in; hy_ff <= hy_in; hz_ff <= hz_in;
      end
   end
endmodule
`default_nettype wire

>>> rtl/core/mesh_bounds_normalizer.sv
// Mesh bounds normaliser. The host sends every vertex twice: first with mode
// accumulate to grow the per-axis bounds, then with mode transform to get the
// vertex mapped into the unit box with a unit normal. Mode clear resets the
// bounds. Only transform items produce a result item.
// Input items arrive on the req_ channel (valid/stall) and enter a two-entry
// queue; the back end takes them one at a time. Clear and accumulate items
// are handled in the idle state when they leave the queue. A transform item
// runs three position divisions, three squaring steps, a square root of 30
// steps and three normal divisions through one shared bit-serial divider of
// 50 steps; a zero normal skips the root and the normal divisions.
// Results leave on the rsp_ channel from an output register; while rsp_stall
// is high the result holds, the back end waits with the next result, and the
// queue keeps accepting items until it is full.
// Configuration writes on the csr_ channel are always taken (csr_ready is
// high) and must happen only while the block is idle.
// Reset empties the queue, drops any result, clears both configuration
// registers and sets the bounds to the empty state.
`default_nettype none
module mesh_bounds_normalizer (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [mbn_pkg::MODE_W-1:0]     req_mode,
   input  wire logic signed [mbn_pkg::POS_W-1:0] req_pos_x,
   input  wire logic signed [mbn_pkg::POS_W-1:0] req_pos_y,
   input  wire logic signed [mbn_pkg::POS_W-1:0] req_pos_z,
   input  wire logic signed [mbn_pkg::NRM_W-1:0] req_norm_x,
   input  wire logic signed [mbn_pkg::NRM_W-1:0] req_norm_y,
   input  wire logic signed [mbn_pkg::NRM_W-1:0] req_norm_z,
   input  wire logic [mbn_pkg::TEX_W-1:0]      req_tex_u,
   input  wire logic [mbn_pkg::TEX_W-1:0]      req_tex_v,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic signed [mbn_pkg::POS_W-1:0]    rsp_out_x,
   output logic signed [mbn_pkg::POS_W-1:0]    rsp_out_y,
   output logic signed [mbn_pkg::POS_W-1:0]    rsp_out_z,
   output logic signed [mbn_pkg::NRM_W-1:0]    rsp_out_nx,
   output logic signed [mbn_pkg::NRM_W-1:0]    rsp_out_ny,
   output logic signed [mbn_pkg::NRM_W-1:0]    rsp_out_nz,
   output logic [mbn_pkg::TEX_W-1:0]           rsp_out_u,
   output logic [mbn_pkg::TEX_W-1:0]           rsp_out_v,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [mbn_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [mbn_pkg::CSR_DATA_W-1:0] csr_data
);
   import mbn_pkg::*;

   item_type      push_item;
   item_type      q_item;
   queue_ctl_type q_ctl;
   logic          q_full;

   assign csr_ready = 1'b1;
   assign req_stall = q_full;

   always_comb begin
      push_item.mode   = req_mode;
      push_item.pos_x  = req_pos_x;
      push_item.pos_y  = req_pos_y;
      push_item.pos_z  = req_pos_z;
      push_item.norm_x = req_norm_x;
      push_item.norm_y = req_norm_y;
      push_item.norm_z = req_norm_z;
      push_item.tex_u  = req_tex_u;
      push_item.tex_v  = req_tex_v;
   end

   mbn_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid),
      .push_item  (push_item),
      .full       (q_full),
      .pop        (q_ctl.pop),
      .item_valid (q_ctl.valid),
      .item       (q_item)
   );

   mbn_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (q_ctl.valid),
      .item       (q_item),
      .item_pop   (q_ctl.pop),
      .csr_write  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_out_x  (rsp_out_x),
      .rsp_out_y  (rsp_out_y),
      .rsp_out_z  (rsp_out_z),
      .rsp_out_nx (rsp_out_nx),
      .rsp_out_ny (rsp_out_ny),
      .rsp_out_nz (rsp_out_nz),
      .rsp_out_u  (rsp_out_u),
      .rsp_out_v  (rsp_out_v)
   );
endmodule
`default_nettype wire
